@@ sv/hbkt_pkg.sv @@
// shared types and constants for the hashed bucket key table
// used by hbkt_ctrl, hbkt_dp and hashed_bucket_key_table_core; no dependencies
package hbkt_pkg;

   localparam logic [63:0] HASH_SEED = 64'd5381;

   // remainder unit: bits folded per cycle and steps per 64-bit hash
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = 64 / MOD_BITS;
   localparam int MOD_CW    = $clog2(MOD_STEPS);

   localparam logic [1:0] KIND_INSERT   = 2'd0;
   localparam logic [1:0] KIND_RETRIEVE = 2'd1;
   localparam logic [1:0] KIND_DELETE   = 2'd2;
   localparam logic [1:0] KIND_NONE     = 2'd3;

   localparam logic [2:0] ST_STORED  = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_HIT     = 3'd2;
   localparam logic [2:0] ST_MISS    = 3'd3;
   localparam logic [2:0] ST_DELETED = 3'd4;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_BASE,
      S_DISP,
      S_POP,
      S_INS,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic byte_acc;
      logic mod_step;
      logic base_ld;
      logic cnt_ld;
      logic set_full;
      logic ins_wr;
      logic scan_chk;
      logic cnt_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic kind_none;
      logic mod_done;
      logic cnt_zero;
      logic is_insert;
      logic is_retrieve;
      logic match;
      logic scan_last;
      logic rsp_free;
   } stat_type;

endpackage

@@ sv/hbkt_ctrl.sv @@
// controller state machine for the hashed bucket key table
// depends on hbkt_pkg; drives hbkt_dp through cmd_type and reads stat_type
module hbkt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tlast,
   output logic               req_tready,
   input  hbkt_pkg::stat_type stat,
   output hbkt_pkg::cmd_type  cmd
);

   hbkt_pkg::state_type state_ff;
   hbkt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbkt_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hbkt_pkg::S_CLEAR: begin
            if (stat.clr_done) state_in = hbkt_pkg::S_IDLE;
         end
         hbkt_pkg::S_IDLE: begin
            if (req_tvalid && req_tlast && !stat.kind_none) state_in = hbkt_pkg::S_MOD;
         end
         hbkt_pkg::S_MOD: begin
            if (stat.mod_done) state_in = hbkt_pkg::S_BASE;
         end
         hbkt_pkg::S_BASE: state_in = hbkt_pkg::S_DISP;
         hbkt_pkg::S_DISP: begin
            if (stat.is_insert) begin
               state_in = stat.cnt_zero ? hbkt_pkg::S_DONE : hbkt_pkg::S_POP;
            end else begin
               state_in = hbkt_pkg::S_SCAN_RD;
            end
         end
         hbkt_pkg::S_POP: state_in = hbkt_pkg::S_INS;
         hbkt_pkg::S_INS: state_in = hbkt_pkg::S_DONE;
         hbkt_pkg::S_SCAN_RD: state_in = hbkt_pkg::S_SCAN_CHK;
         hbkt_pkg::S_SCAN_CHK: begin
            if ((stat.is_retrieve && stat.match) || stat.scan_last) begin
               state_in = hbkt_pkg::S_DONE;
            end else begin
               state_in = hbkt_pkg::S_SCAN_RD;
            end
         end
         hbkt_pkg::S_DONE: begin
            if (stat.rsp_free) state_in = hbkt_pkg::S_IDLE;
         end
         default: state_in = hbkt_pkg::S_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         hbkt_pkg::S_CLEAR: cmd.clr_step = 1'b1;
         hbkt_pkg::S_IDLE: begin
            req_tready   = 1'b1;
            cmd.byte_acc = req_tvalid;
         end
         hbkt_pkg::S_MOD:  cmd.mod_step = 1'b1;
         hbkt_pkg::S_BASE: cmd.base_ld = 1'b1;
         hbkt_pkg::S_DISP: begin
            cmd.cnt_ld   = 1'b1;
            cmd.set_full = stat.is_insert && stat.cnt_zero;
         end
         hbkt_pkg::S_POP:      cmd = '0;
         hbkt_pkg::S_INS:      cmd.ins_wr = 1'b1;
         hbkt_pkg::S_SCAN_RD:  cmd = '0;
         hbkt_pkg::S_SCAN_CHK: cmd.scan_chk = 1'b1;
         hbkt_pkg::S_DONE: begin
            cmd.cnt_wr   = 1'b1;
            cmd.rsp_load = stat.rsp_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

@@ sv/hbkt_dp.sv @@
// datapath of the hashed bucket key table: hash, remainder unit, slot,
// free stack and count memories, result register; depends on hbkt_pkg
module hbkt_dp #(
   parameter int NUM_BUCKETS      = 16,
   parameter int SLOTS_PER_BUCKET = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  hbkt_pkg::cmd_type  cmd,
   output hbkt_pkg::stat_type stat,
   input  logic [1:0]         req_tuser,
   input  logic [71:0]        req_tdata,
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [71:0]        rsp_tdata,
   output logic [2:0]         rsp_tuser
);

   localparam int TOTAL = NUM_BUCKETS * SLOTS_PER_BUCKET;
   localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int RBW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int CW    = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int RCW   = (CW > 4) ? CW : 4;
   localparam logic [RBW:0]   NUM_T   = (RBW + 1)'(NUM_BUCKETS);
   localparam logic [AW-1:0]  SLOTS_A = AW'(SLOTS_PER_BUCKET);
   localparam logic [AW-1:0]  LAST_A  = AW'(TOTAL - 1);
   localparam logic [SW-1:0]  LAST_S  = SW'(SLOTS_PER_BUCKET - 1);
   localparam logic [CW-1:0]  FULL_C  = CW'(SLOTS_PER_BUCKET);

   logic              slot_valid_mem [TOTAL];
   logic [63:0]       slot_hash_mem  [TOTAL];
   logic [63:0]       slot_value_mem [TOTAL];
   logic [SW-1:0]     stack_mem      [TOTAL];
   logic [CW-1:0]     cnt_mem        [NUM_BUCKETS];

   logic              slot_valid_rd_ff;
   logic [63:0]       slot_hash_rd_ff;
   logic [63:0]       slot_value_rd_ff;
   logic [SW-1:0]     stack_rd_ff;
   logic [CW-1:0]     cnt_rd_ff;

   logic [63:0]       hash_ff, hash_in;
   logic [63:0]       key_ff, value_ff;
   logic [1:0]        kind_ff;
   logic [63:0]       sh_ff;
   logic [hbkt_pkg::MOD_CW-1:0] mod_cnt_ff;
   logic [RBW-1:0]    rem_ff, rem_in;
   logic [AW-1:0]     base_ff;
   logic [CW-1:0]     cnt_ff;
   logic [SW-1:0]     scan_s_ff;
   logic [2:0]        res_status_ff;
   logic [63:0]       res_found_ff;
   logic [RCW-1:0]    removed_ff;
   logic [AW-1:0]     clr_addr_ff;
   logic [SW-1:0]     clr_slot_ff;
   logic [RBW-1:0]    clr_bucket_ff;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_status_ff;
   logic [63:0]       rsp_found_ff;
   logic [3:0]        rsp_removed_ff;

   logic [7:0]        key_byte;
   logic              is_delete, match;
   logic              slot_we, stack_we, cnt_we;
   logic [AW-1:0]     slot_wa, stack_wa, slot_ra, stack_ra, scan_addr;
   logic [SW-1:0]     stack_wd;
   logic [RBW-1:0]    cnt_wa;
   logic [CW-1:0]     cnt_wd;

   assign key_byte  = req_tdata[7:0];
   assign hash_in   = (hash_ff << 5) + hash_ff + {{56{key_byte[7]}}, key_byte};
   assign is_delete = (kind_ff == hbkt_pkg::KIND_DELETE);
   assign match     = slot_valid_rd_ff && (slot_hash_rd_ff == key_ff);
   assign scan_addr = base_ff + AW'(scan_s_ff);
   assign slot_ra   = scan_addr;
   assign stack_ra  = base_ff + AW'(cnt_ff) - AW'(1);

   // remainder of the hash, MOD_BITS bits per cycle, msb first
   always_comb begin
      logic [RBW:0] t;
      rem_in = rem_ff;
      t      = '0;
      for (int j = 0; j < hbkt_pkg::MOD_BITS; j++) begin
         t = {rem_in, sh_ff[63 - j]};
         if (t >= NUM_T) t = t - NUM_T;
         rem_in = t[RBW-1:0];
      end
   end

   always_comb begin
      slot_we  = cmd.clr_step || cmd.ins_wr || (cmd.scan_chk && is_delete && match);
      stack_we = cmd.clr_step || (cmd.scan_chk && is_delete && match);
      cnt_we   = cmd.clr_step || cmd.cnt_wr;
      if (cmd.clr_step) begin
         slot_wa = clr_addr_ff;
      end else if (cmd.ins_wr) begin
         slot_wa = base_ff + AW'(stack_rd_ff);
      end else begin
         slot_wa = scan_addr;
      end
      stack_wa = cmd.clr_step ? clr_addr_ff : (base_ff + AW'(cnt_ff));
      stack_wd = cmd.clr_step ? clr_slot_ff : scan_s_ff;
      cnt_wa   = cmd.clr_step ? clr_bucket_ff : rem_ff;
      cnt_wd   = cmd.clr_step ? FULL_C : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_valid_mem[slot_wa] <= cmd.ins_wr;
         slot_hash_mem[slot_wa]  <= key_ff;
         slot_value_mem[slot_wa] <= value_ff;
      end
      slot_valid_rd_ff <= slot_valid_mem[slot_ra];
      slot_hash_rd_ff  <= slot_hash_mem[slot_ra];
      slot_value_rd_ff <= slot_value_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_wa] <= stack_wd;
      stack_rd_ff <= stack_mem[stack_ra];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      cnt_rd_ff <= cnt_mem[rem_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff       <= hbkt_pkg::HASH_SEED;
         clr_addr_ff   <= '0;
         clr_slot_ff   <= '0;
         clr_bucket_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.byte_acc) hash_ff <= req_tlast ? hbkt_pkg::HASH_SEED : hash_in;
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_slot_ff == LAST_S) begin
               clr_slot_ff   <= '0;
               clr_bucket_ff <= clr_bucket_ff + RBW'(1);
            end else begin
               clr_slot_ff <= clr_slot_ff + SW'(1);
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_acc && req_tlast) begin
         key_ff        <= hash_in;
         sh_ff         <= hash_in;
         value_ff      <= req_tdata[71:8];
         kind_ff       <= req_tuser;
         mod_cnt_ff    <= '0;
         rem_ff        <= '0;
         res_status_ff <= hbkt_pkg::ST_MISS;
         res_found_ff  <= '0;
         removed_ff    <= '0;
      end
      if (cmd.mod_step) begin
         sh_ff      <= sh_ff << hbkt_pkg::MOD_BITS;
         rem_ff     <= rem_in;
         mod_cnt_ff <= mod_cnt_ff + hbkt_pkg::MOD_CW'(1);
      end
      if (cmd.base_ld) base_ff <= AW'(rem_ff) * SLOTS_A;
      if (cmd.cnt_ld) begin
         cnt_ff    <= cnt_rd_ff;
         scan_s_ff <= '0;
      end
      if (cmd.set_full) res_status_ff <= hbkt_pkg::ST_FULL;
      if (cmd.ins_wr) begin
         res_status_ff <= hbkt_pkg::ST_STORED;
         cnt_ff        <= cnt_ff - CW'(1);
      end
      if (cmd.scan_chk) begin
         scan_s_ff <= scan_s_ff + SW'(1);
         if (is_delete) begin
            res_status_ff <= hbkt_pkg::ST_DELETED;
            if (match) begin
               cnt_ff     <= cnt_ff + CW'(1);
               removed_ff <= removed_ff + RCW'(1);
            end
         end else if (match) begin
            res_status_ff <= hbkt_pkg::ST_HIT;
            res_found_ff  <= slot_value_rd_ff;
         end
      end
      if (cmd.rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_found_ff   <= res_found_ff;
         rsp_removed_ff <= removed_ff[3:0];
      end
   end

   always_comb begin
      stat.clr_done    = (clr_addr_ff == LAST_A);
      stat.kind_none   = (req_tuser == hbkt_pkg::KIND_NONE);
      stat.mod_done    = (mod_cnt_ff == hbkt_pkg::MOD_CW'(hbkt_pkg::MOD_STEPS - 1));
      stat.cnt_zero    = (cnt_rd_ff == '0);
      stat.is_insert   = (kind_ff == hbkt_pkg::KIND_INSERT);
      stat.is_retrieve = (kind_ff == hbkt_pkg::KIND_RETRIEVE);
      stat.match       = match;
      stat.scan_last   = (scan_s_ff == LAST_S);
      stat.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0000, rsp_removed_ff, rsp_found_ff};

endmodule

@@ sv/hashed_bucket_key_table_core.sv @@
// Hash table with a byte-serial key: each key byte folds into a 64-bit djb2
// hash (h*33 + signed byte), and the word flagged tlast runs insert, retrieve
// or delete on bucket hash mod NUM_BUCKETS; kind none only restarts the hash.
// After the last byte the hash remainder is folded four bits per cycle, then
// comes the bucket setup (S_BASE, S_DISP); insert pops a free slot and writes
// it (neither when the bucket is full), retrieve or delete read and check the
// bucket's slots in turn, up to SLOTS_PER_BUCKET, retrieve stopping at a hit;
// last the result register is loaded, which waits while the previous result is
// still held. After reset a clearing pass over all NUM_BUCKETS*SLOTS_PER_BUCKET
// slots fills the free slot stacks while no word is taken.
// depends on hbkt_pkg, hbkt_ctrl and hbkt_dp
module hashed_bucket_key_table_core #(
   parameter int NUM_BUCKETS      = 16,
   parameter int SLOTS_PER_BUCKET = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // key_byte[7:0], value[71:8]
   input  logic [1:0]  req_tuser,  // kind[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // found_value[63:0], removed_count[67:64], zero pad
   output logic [2:0]  rsp_tuser   // status[2:0]
);

   hbkt_pkg::cmd_type  cmd;
   hbkt_pkg::stat_type stat;

   hbkt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hbkt_dp #(
      .NUM_BUCKETS      (NUM_BUCKETS),
      .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_found_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != hbkt_pkg::ST_HIT) |-> (rsp_tdata[63:0] == 64'd0))
      else $error("found_value nonzero without hit");

   a_removed_only_on_delete: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != hbkt_pkg::ST_DELETED) |-> (rsp_tdata[67:64] == 4'd0))
      else $error("removed_count nonzero outside delete");

   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready && !$past(req_tready) |-> $past(stat.rsp_free) || $past(stat.clr_done))
      else $error("returned to idle without result slot");

endmodule

@@ tb/tb_hashed_bucket_key_table_core.sv @@
// testbench for hashed_bucket_key_table_core: drives random and directed key
// words, predicts table results with a behavioral bucket model, checks responses
// depends on hbkt_pkg and hashed_bucket_key_table_core
class table_scoreboard;
   localparam int NB = 16;
   localparam int NS = 8;
   bit          slot_on [NB*NS];
   logic [63:0] slot_hash [NB*NS];
   logic [63:0] slot_val [NB*NS];
   logic [2:0]  free_idx [NB*NS];
   int          free_cnt [NB];
   logic [63:0] hash_acc;
   logic [2:0]  want_status [$];
   logic [63:0] want_value [$];
   logic [3:0]  want_removed [$];
   int          errors;
   int          checked;

   function void clear_table();
      hash_acc = hbkt_pkg::HASH_SEED;
      for (int b = 0; b < NB; b++) begin
         free_cnt[b] = NS;
         for (int s = 0; s < NS; s++) begin
            slot_on[b*NS+s] = 0;
            free_idx[b*NS+s] = s[2:0];
         end
      end
   endfunction

   function void note_word(logic [1:0] kind, logic [7:0] kbyte, logic last, logic [63:0] val);
      logic [63:0] h;
      int b, n;
      logic [2:0] st;
      logic [63:0] fv;
      int rm;
      h = hash_acc * 64'd33 + {{56{kbyte[7]}}, kbyte};
      hash_acc = h;
      if (!last) return;
      hash_acc = hbkt_pkg::HASH_SEED;
      if (kind == hbkt_pkg::KIND_NONE) return;
      b = int'(h[3:0]);
      fv = '0;
      rm = 0;
      if (kind == hbkt_pkg::KIND_INSERT) begin
         if (free_cnt[b] == 0) st = hbkt_pkg::ST_FULL;
         else begin
            free_cnt[b]--;
            n = b*NS + free_idx[b*NS+free_cnt[b]];
            slot_on[n] = 1;
            slot_hash[n] = h;
            slot_val[n] = val;
            st = hbkt_pkg::ST_STORED;
         end
      end else if (kind == hbkt_pkg::KIND_RETRIEVE) begin
         st = hbkt_pkg::ST_MISS;
         for (int s = 0; s < NS; s++)
            if (st == hbkt_pkg::ST_MISS && slot_on[b*NS+s] && slot_hash[b*NS+s] == h) begin
               st = hbkt_pkg::ST_HIT;
               fv = slot_val[b*NS+s];
            end
      end else begin
         for (int s = 0; s < NS; s++)
            if (slot_on[b*NS+s] && slot_hash[b*NS+s] == h) begin
               slot_on[b*NS+s] = 0;
               if (free_cnt[b] < NS) begin
                  free_idx[b*NS+free_cnt[b]] = s[2:0];
                  free_cnt[b]++;
               end
               rm++;
            end
         st = hbkt_pkg::ST_DELETED;
      end
      want_status.push_back(st);
      want_value.push_back(fv);
      want_removed.push_back(rm[3:0]);
   endfunction

   function void check_result(logic [2:0] st, logic [63:0] fv, logic [3:0] rm);
      logic [2:0] es;
      logic [63:0] ev;
      logic [3:0] er;
      if (want_status.size() == 0) begin
         $display("%0t unexpected result status %0d", $time, st);
         errors++;
         return;
      end
      es = want_status.pop_front();
      ev = want_value.pop_front();
      er = want_removed.pop_front();
      checked++;
      if (st !== es) begin
         $display("%0t status expected %0d actual %0d", $time, es, st);
         errors++;
      end
      if (fv !== ev) begin
         $display("%0t found_value expected %h actual %h", $time, ev, fv);
         errors++;
      end
      if (rm !== er) begin
         $display("%0t removed_count expected %0d actual %0d", $time, er, rm);
         errors++;
      end
   endfunction
endclass

module tb_hashed_bucket_key_table_core;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;  // key_byte[7:0], value[71:8]
   logic [1:0]  req_tuser;  // kind[1:0]
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;  // found_value[63:0], removed_count[67:64], zero pad
   logic [2:0]  rsp_tuser;  // status[2:0]

   table_scoreboard sb;
   int unsigned cycle_count;
   int          key_count;
   logic [7:0]  saved_keys [8][4];
   int          saved_len [8];

   hashed_bucket_key_table_core dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   task automatic send_word(logic [1:0] kind, logic [7:0] kbyte, logic last,
                            logic [63:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {val, kbyte};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(kind, kbyte, last, val);
   endtask

   task automatic send_key(logic [1:0] kind, int slot, logic [63:0] val);
      for (int i = 0; i < saved_len[slot]; i++)
         send_word(kind, saved_keys[slot][i], i == saved_len[slot] - 1, val);
      key_count++;
   endtask

   task automatic make_key(int slot);
      saved_len[slot] = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) saved_keys[slot][i] = $urandom;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser, rsp_tdata[63:0], rsp_tdata[67:64]);
      if (cycle_count > 1500000) begin
         $display("[hashed_bucket_key_table_core] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if ($urandom_range(0, 99) < 5) rsp_tready <= 0;
      else if (!rsp_tready) rsp_tready <= (pick_gap() == 0);
      else rsp_tready <= ($urandom_range(0, 99) < 75) || ($urandom_range(0, 3) != 0);
   end

   initial begin
      int r;
      int s;
      sb = new();
      sb.clear_table();
      cycle_count = 0;
      key_count = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 0;
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed: extremes, every kind, bucket overflow, miss and multi delete
      saved_len[0] = 1;
      saved_keys[0][0] = 8'hFF;
      saved_len[1] = 2;
      saved_keys[1][0] = 8'h00;
      saved_keys[1][1] = 8'h80;
      send_key(hbkt_pkg::KIND_RETRIEVE, 0, '0);
      send_key(hbkt_pkg::KIND_DELETE, 0, '0);
      for (int i = 0; i < 9; i++) send_key(hbkt_pkg::KIND_INSERT, 0, i[0] ? '1 : 64'h0);
      send_key(hbkt_pkg::KIND_RETRIEVE, 0, '0);
      send_key(hbkt_pkg::KIND_NONE, 1, '1);
      send_key(hbkt_pkg::KIND_INSERT, 1, 64'h8000_0000_0000_0001);
      send_key(hbkt_pkg::KIND_RETRIEVE, 1, '0);
      send_key(hbkt_pkg::KIND_DELETE, 0, '0);
      send_key(hbkt_pkg::KIND_RETRIEVE, 0, '0);
      send_key(hbkt_pkg::KIND_DELETE, 1, '0);
      send_key(hbkt_pkg::KIND_DELETE, 1, '0);

      // random: keys drawn mostly from a small reused pool
      for (int i = 0; i < 8; i++) make_key(i);
      while (key_count < 560) begin
         r = $urandom_range(0, 99);
         s = $urandom_range(0, 7);
         if ($urandom_range(0, 49) == 0) make_key(s);
         if (r < 40) send_key(hbkt_pkg::KIND_INSERT, s, rand64());
         else if (r < 70) send_key(hbkt_pkg::KIND_RETRIEVE, s, rand64());
         else if (r < 88) send_key(hbkt_pkg::KIND_DELETE, s, rand64());
         else if (r < 93) send_key(hbkt_pkg::KIND_NONE, s, rand64());
         else begin
            make_key(s);
            send_key(r[0] ? hbkt_pkg::KIND_INSERT : hbkt_pkg::KIND_RETRIEVE, s, rand64());
         end
      end
      req_tvalid <= 0;

      while (sb.want_status.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d keys with %0d checked results across insert, retrieve, delete",
               key_count, sb.checked);
      if (sb.errors == 0) $display("[hashed_bucket_key_table_core] OK");
      else $display("[hashed_bucket_key_table_core] ERROR");
      $finish;
   end
endmodule
